// ----- src/positional_insert_delete_array_macros.svh -----
// Assertion macros shared by the positional insert/delete array modules.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define PIDA_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pida assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define PIDA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pida assertion failed");
// Consequent holds in the cycle after the antecedent.
`define PIDA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pida assertion failed");
`else
`define PIDA_ASSERT_ALWAYS(name, clk, rst_n, cond)
`define PIDA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PIDA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/pida_pkg.sv -----
// Shared constants and control/status types of the positional insert/delete array.
package pida_pkg;

    // Default number of entries
    localparam int DEPTH_DEFAULT = 64;

    // Request kinds
    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_APPEND = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_INSERT = 3'd3;
    localparam logic [2:0] REQ_DELETE = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_req;     // capture request fields
        logic apply_simple; // finish clear, append, error and unused kinds
        logic read_pos;     // issue memory read at the requested position
        logic idx_init;     // start a shift walk
        logic loop_read;    // read the neighbor of the walk index
        logic loop_write;   // write the neighbor into the walk index
        logic finish_shift; // final write / count update of insert or delete
        logic load_result;  // latch result and raise the strobe
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic go_read;  // valid read request
        logic go_shift; // valid insert or delete request
        logic loop_end; // shift walk has reached its end
    } sts_t;

endpackage

// ----- src/pida_datapath.sv -----
// Datapath: element memory, count, request checks, shift walk index and result registers.
`include "positional_insert_delete_array_macros.svh"

module pida_datapath #(
    parameter int DEPTH = pida_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [6:0]         position,
    input  pida_pkg::cmd_t     cmd,
    output pida_pkg::sts_t     sts,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] read_value,
    output logic [6:0]         count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW + 1 > 7) ? CW + 1 : 7;

    logic [2:0]         kind_reg;
    logic signed [31:0] val_reg;
    logic [6:0]         pos_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic [31:0]        rdata_reg;
    logic [31:0]        mem [DEPTH];
    logic               done_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] rv_reg;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [AW-1:0] pos_m1;
    logic          full;
    logic          empty;
    logic [1:0]    status_c;
    logic          is_ok;
    logic          is_insert;
    logic          is_delete;
    logic          we;
    logic          re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [31:0]   wdata;

    // Request checks
    always_comb
    begin
        pos_x     = XW'(pos_reg);
        cnt_x     = XW'(count_reg);
        pos_m1    = AW'(pos_x - XW'(1));
        full      = (count_reg == CW'(DEPTH));
        empty     = (count_reg == '0);
        is_insert = (kind_reg == pida_pkg::REQ_INSERT);
        is_delete = (kind_reg == pida_pkg::REQ_DELETE);
        case (kind_reg) inside
            pida_pkg::REQ_APPEND:
            begin
                status_c = full ? pida_pkg::ST_FULL : pida_pkg::ST_OK;
            end
            pida_pkg::REQ_READ, pida_pkg::REQ_DELETE:
            begin
                if (empty)
                    status_c = pida_pkg::ST_EMPTY;
                else if (pos_x == '0 || pos_x > cnt_x)
                    status_c = pida_pkg::ST_BADPOS;
                else
                    status_c = pida_pkg::ST_OK;
            end
            pida_pkg::REQ_INSERT:
            begin
                if (full)
                    status_c = pida_pkg::ST_FULL;
                else if (pos_x == '0 || pos_x > cnt_x + XW'(1))
                    status_c = pida_pkg::ST_BADPOS;
                else
                    status_c = pida_pkg::ST_OK;
            end
            default:
            begin
                status_c = pida_pkg::ST_OK;
            end
        endcase
        is_ok        = (status_c == pida_pkg::ST_OK);
        sts.go_read  = is_ok && (kind_reg == pida_pkg::REQ_READ);
        sts.go_shift = is_ok && (is_insert || is_delete);
        // insert walks down to the target slot, delete walks up to the last entry
        sts.loop_end = is_insert ? (idx_reg == pos_m1)
                                 : ((XW'(idx_reg) + XW'(1)) >= cnt_x);
    end

    // Memory port control
    always_comb
    begin
        re = cmd.read_pos || cmd.loop_read;
        if (cmd.read_pos)
            raddr = pos_m1;
        else if (is_insert)
            raddr = idx_reg - AW'(1);
        else
            raddr = idx_reg + AW'(1);
        we = (cmd.apply_simple && kind_reg == pida_pkg::REQ_APPEND && is_ok)
            || cmd.loop_write || (cmd.finish_shift && is_insert);
        waddr = cmd.apply_simple ? AW'(count_reg) : idx_reg;
        wdata = cmd.loop_write ? rdata_reg : val_reg;
    end

    // Element storage, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Count and walk index updates
    always_comb
    begin
        count_next = count_reg;
        if (cmd.apply_simple)
        begin
            if (kind_reg == pida_pkg::REQ_CLEAR)
                count_next = '0;
            else if (kind_reg == pida_pkg::REQ_APPEND && is_ok)
                count_next = count_reg + CW'(1);
        end
        else if (cmd.finish_shift)
        begin
            count_next = is_insert ? count_reg + CW'(1) : count_reg - CW'(1);
        end
        idx_next = idx_reg;
        if (cmd.idx_init)
            idx_next = is_insert ? AW'(count_reg) : pos_m1;
        else if (cmd.loop_write)
            idx_next = is_insert ? idx_reg - AW'(1) : idx_reg + AW'(1);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.load_result;
        end
    end

    // Request and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= req_type;
            val_reg  <= value;
            pos_reg  <= position;
        end
        idx_reg <= idx_next;
        if (cmd.load_result)
        begin
            status_reg <= status_c;
            rv_reg     <= sts.go_read ? $signed(rdata_reg) : '0;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = rv_reg;
    assign count      = 7'(count_reg);

    `PIDA_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH))
    `PIDA_ASSERT_IMP(a_write_after_read, clk, rst_n, cmd.loop_write, $past(cmd.loop_read))
    `PIDA_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)

endmodule

// ----- src/pida_ctrl.sv -----
// Controller: request sequencing state machine for the positional insert/delete array.
`include "positional_insert_delete_array_macros.svh"

module pida_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pida_pkg::sts_t sts,
    output pida_pkg::cmd_t cmd,
    output logic           busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_RDOUT = 5'b00100,
        S_LOOP  = 5'b01000,
        S_SHIFT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.go_read)
                begin
                    cmd.read_pos = 1'b1;
                    state_next   = S_RDOUT;
                end
                else if (sts.go_shift)
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_LOOP;
                end
                else
                begin
                    cmd.apply_simple = 1'b1;
                    cmd.load_result  = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_RDOUT:
            begin
                cmd.load_result = 1'b1;
                state_next      = S_IDLE;
            end
            S_LOOP:
            begin
                if (sts.loop_end)
                begin
                    cmd.finish_shift = 1'b1;
                    cmd.load_result  = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cmd.loop_read = 1'b1;
                    state_next    = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.loop_write = 1'b1;
                state_next     = S_LOOP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    `PIDA_ASSERT_NEXT(a_result_to_idle, clk, rst_n, cmd.load_result, state_reg == S_IDLE)
    `PIDA_ASSERT_NEXT(a_start_to_check, clk, rst_n, start && !busy, state_reg == S_CHECK)
    `PIDA_ASSERT_IMP(a_shift_from_loop, clk, rst_n, state_reg == S_SHIFT,
                     $past(state_reg) == S_LOOP)

endmodule

// ----- src/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete array: controller plus datapath.
//
// Holds up to DEPTH signed 32-bit entries packed from position 1 and a count.
// A request (req_type, value, position) is taken at a clock edge where start
// is high and busy is low. Kinds: clear, append, read, insert, delete.
// Exactly one result per request: done is high for one cycle with status,
// read_value and count valid; the receiver must take it in that cycle.
// Steps from the accepting edge to the done cycle:
//   clear, append, unused kinds and all rejected requests: check state only
//   read: check state (memory read issued), then read-out state
//   insert at position p: check, count - p + 1 entry moves, final write
//   delete at position p: check, count - p entry moves, count update
// Entries move through a single memory with one write and one registered
// read port; a read and a write state per entry set the insert/delete time.
// busy drops in the done cycle, so the next request may be taken at the
// edge that ends it. Reset empties the array at once (count zero); the
// entries themselves are not cleared and need no clearing pass.
module positional_insert_delete_array #(
    parameter int DEPTH = pida_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [6:0]         position,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] read_value,
    output logic [6:0]         count
);

    pida_pkg::cmd_t cmd;
    pida_pkg::sts_t sts;

    pida_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pida_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .cmd        (cmd),
        .sts        (sts),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

endmodule
